FILE: design/der_cert_serial_issuer_extractor_defines.svh
// Assertion macros for the DER certificate serial and issuer extractor.
`ifndef DER_CERT_SERIAL_ISSUER_EXTRACTOR_DEFINES_SVH
`define DER_CERT_SERIAL_ISSUER_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DCSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DCSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/der_csi_pkg.sv
// Shared types, codes and helpers for the DER certificate serial and issuer extractor.
package der_csi_pkg;

    // Longest long-form length field accepted
    localparam int MAX_LEN_BYTES = 4;

    // Parse phase, one-hot
    typedef enum logic [10:0] {
        P_OUTER   = 11'b000_0000_0001,
        P_TBS     = 11'b000_0000_0010,
        P_FIRST   = 11'b000_0000_0100,
        P_VERBODY = 11'b000_0000_1000,
        P_SERIAL  = 11'b000_0001_0000,
        P_SERBODY = 11'b000_0010_0000,
        P_ALG     = 11'b000_0100_0000,
        P_ALGBODY = 11'b000_1000_0000,
        P_ISS     = 11'b001_0000_0000,
        P_ISSBODY = 11'b010_0000_0000,
        P_TAIL    = 11'b100_0000_0000
    } phase_t;

    // Header byte position, one-hot
    typedef enum logic [2:0] {
        HS_TAG = 3'b001,
        HS_LEN = 3'b010,
        HS_EXT = 3'b100
    } hstep_t;

    // Verdict codes
    localparam logic [3:0] ST_BUSY    = 4'd0;
    localparam logic [3:0] ST_OK      = 4'd1;
    localparam logic [3:0] ST_TRUNC   = 4'd2;
    localparam logic [3:0] ST_BADLEN  = 4'd3;
    localparam logic [3:0] ST_OVER    = 4'd4;
    localparam logic [3:0] ST_NOTCERT = 4'd5;
    localparam logic [3:0] ST_NOTTBS  = 4'd6;
    localparam logic [3:0] ST_NOTSER  = 4'd7;
    localparam logic [3:0] ST_NOTISS  = 4'd8;

    // Byte marks
    localparam logic [1:0] PART_NONE   = 2'd0;
    localparam logic [1:0] PART_SERIAL = 2'd1;
    localparam logic [1:0] PART_ISSUER = 2'd2;

    // Tag values
    localparam logic [7:0] TAG_VERSION = 8'hA0;
    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [4:0] TAG_SEQ_NUM = 5'h10;

    localparam logic [32:0] SEEN_MAX = '1;

    // Parser state
    typedef struct packed {
        phase_t      phase;
        hstep_t      hstep;
        logic [2:0]  len_left;
        logic [31:0] len_acc;
        logic [32:0] seen;
        logic [33:0] outer_end;
        logic [31:0] tbs_left;
        logic [31:0] elem_left;
        logic [3:0]  err;
        logic [7:0]  tag;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:     P_OUTER,
        hstep:     HS_TAG,
        len_left:  3'd0,
        len_acc:   32'd0,
        seen:      33'd0,
        outer_end: 34'd0,
        tbs_left:  32'd0,
        elem_left: 32'd0,
        err:       ST_BUSY,
        tag:       8'd0
    };

    // Phase that follows a finished element body
    function automatic phase_t body_next(input phase_t p);
        phase_t r;
        unique case (p)
            P_VERBODY: r = P_SERIAL;
            P_SERBODY: r = P_ALG;
            P_ALGBODY: r = P_ISS;
            default:   r = P_TAIL;
        endcase
        return r;
    endfunction

endpackage

FILE: design/der_csi_step.sv
// One-byte parse step: next parser state, byte mark and frame verdict.
module der_csi_step (
    input  der_csi_pkg::state_t st_i,
    input  logic [7:0]          byte_i,
    input  logic                last_i,
    output der_csi_pkg::state_t st_o,
    output logic [1:0]          part_o,
    output logic [3:0]          status_o
);
    import der_csi_pkg::*;

    state_t      nxt;
    logic [31:0] dec_elem;
    logic [31:0] dec_tbs;
    logic [32:0] seen_inc;
    logic [31:0] room;
    logic        bounded;
    logic        is_hdr;
    logic [6:0]  cnt;
    logic [2:0]  left_dec;
    logic        done;
    logic        herr;
    logic [3:0]  fcode;
    logic        outer_done;
    logic        open_en;
    phase_t      open_ph;
    logic        bd_en;
    phase_t      bd_from;
    logic        lt_outer;

    // Saturating counters and header room
    assign dec_elem = (st_i.elem_left != 32'd0) ? st_i.elem_left - 32'd1 : 32'd0;
    assign dec_tbs  = (st_i.tbs_left != 32'd0) ? st_i.tbs_left - 32'd1 : 32'd0;
    assign seen_inc = (st_i.seen != SEEN_MAX) ? st_i.seen + 33'd1 : st_i.seen;
    assign room     = (st_i.phase == P_TBS) ? dec_elem : dec_tbs;
    assign bounded  = (st_i.phase != P_OUTER);
    assign is_hdr   = (st_i.phase == P_OUTER) || (st_i.phase == P_TBS) ||
                      (st_i.phase == P_FIRST) || (st_i.phase == P_SERIAL) ||
                      (st_i.phase == P_ALG)   || (st_i.phase == P_ISS);
    assign cnt      = byte_i[6:0];
    assign left_dec = (st_i.len_left != 3'd0) ? st_i.len_left - 3'd1 : 3'd0;

    always_comb begin
        nxt        = st_i;
        nxt.seen   = seen_inc;
        done       = 1'b0;
        herr       = 1'b0;
        fcode      = ST_BUSY;
        outer_done = 1'b0;
        open_en    = 1'b0;
        open_ph    = P_TAIL;
        bd_en      = 1'b0;
        bd_from    = P_TAIL;
        lt_outer   = 1'b0;
        part_o     = PART_NONE;
        status_o   = ST_BUSY;

        // Tag-length header byte
        if (st_i.err == ST_BUSY && is_hdr) begin
            unique case (st_i.hstep)
                HS_TAG: begin
                    nxt.tag   = byte_i;
                    nxt.hstep = HS_LEN;
                end
                HS_LEN: begin
                    if (!byte_i[7]) begin
                        nxt.len_acc = {24'd0, byte_i};
                        nxt.hstep   = HS_TAG;
                        done        = 1'b1;
                    end else if (cnt == 7'd0 || cnt > 7'(MAX_LEN_BYTES) ||
                                 (bounded && {25'd0, cnt} > room)) begin
                        herr = 1'b1;
                    end else begin
                        nxt.len_left = cnt[2:0];
                        nxt.len_acc  = 32'd0;
                        nxt.hstep    = HS_EXT;
                    end
                end
                HS_EXT: begin
                    nxt.len_acc  = {st_i.len_acc[23:0], byte_i};
                    nxt.len_left = left_dec;
                    if (left_dec == 3'd0) begin
                        nxt.hstep = HS_TAG;
                        done      = 1'b1;
                    end
                end
                default: nxt.hstep = HS_TAG;
            endcase
        end

        // Phase work
        if (st_i.err == ST_BUSY) begin
            unique case (st_i.phase)
                P_OUTER: begin
                    if (herr) begin
                        fcode = ST_BADLEN;
                    end else if (done) begin
                        outer_done    = 1'b1;
                        nxt.outer_end = {1'b0, seen_inc} + {2'b00, nxt.len_acc};
                        if (nxt.tag[4:0] != TAG_SEQ_NUM) begin
                            fcode = ST_NOTCERT;
                        end else begin
                            nxt.elem_left = nxt.len_acc;
                            nxt.phase     = P_TBS;
                            if (nxt.len_acc < 32'd2) fcode = ST_TRUNC;
                        end
                    end
                end
                P_TBS: begin
                    nxt.elem_left = dec_elem;
                    if (herr) begin
                        fcode = ST_BADLEN;
                    end else if (done) begin
                        if (nxt.len_acc > dec_elem) begin
                            fcode = ST_OVER;
                        end else if (nxt.tag[4:0] != TAG_SEQ_NUM) begin
                            fcode = ST_NOTTBS;
                        end else begin
                            nxt.tbs_left = nxt.len_acc;
                            nxt.phase    = P_FIRST;
                            if (nxt.len_acc < 32'd2) fcode = ST_TRUNC;
                        end
                    end
                end
                P_FIRST, P_SERIAL, P_ALG, P_ISS: begin
                    nxt.tbs_left = dec_tbs;
                    if (herr) begin
                        fcode = ST_BADLEN;
                    end else if (done) begin
                        if (nxt.len_acc > dec_tbs) begin
                            fcode = ST_OVER;
                        end else if (st_i.phase == P_FIRST && nxt.tag == TAG_VERSION) begin
                            open_en = 1'b1;
                            open_ph = P_VERBODY;
                        end else if (st_i.phase == P_FIRST || st_i.phase == P_SERIAL) begin
                            if (nxt.tag != TAG_INTEGER) begin
                                fcode = ST_NOTSER;
                            end else begin
                                open_en = 1'b1;
                                open_ph = P_SERBODY;
                            end
                        end else if (st_i.phase == P_ALG) begin
                            open_en = 1'b1;
                            open_ph = P_ALGBODY;
                        end else if (nxt.tag[4:0] != TAG_SEQ_NUM) begin
                            fcode = ST_NOTISS;
                        end else begin
                            open_en = 1'b1;
                            open_ph = P_ISSBODY;
                        end
                    end
                end
                P_VERBODY, P_SERBODY, P_ALGBODY, P_ISSBODY: begin
                    nxt.tbs_left  = dec_tbs;
                    nxt.elem_left = dec_elem;
                    if (dec_elem == 32'd0) begin
                        bd_en   = 1'b1;
                        bd_from = st_i.phase;
                    end
                end
                default: ;
            endcase
        end

        // Enter an element body; an empty body finishes at once
        if (open_en) begin
            nxt.elem_left = nxt.len_acc;
            if (nxt.len_acc == 32'd0) begin
                bd_en   = 1'b1;
                bd_from = open_ph;
            end else begin
                nxt.phase = open_ph;
            end
        end

        // Body finished: next header needs two bytes of room
        if (bd_en) begin
            nxt.phase = body_next(bd_from);
            if (nxt.phase != P_TAIL) begin
                nxt.hstep = HS_TAG;
                if (nxt.tbs_left < 32'd2) fcode = ST_TRUNC;
            end
        end

        // Sticky error
        if (fcode != ST_BUSY) begin
            nxt.err   = fcode;
            nxt.phase = P_TAIL;
        end

        // Byte mark
        if (nxt.err == ST_BUSY) begin
            unique case (st_i.phase)
                P_FIRST, P_SERIAL: part_o = (nxt.tag == TAG_INTEGER) ? PART_SERIAL : PART_NONE;
                P_SERBODY:         part_o = PART_SERIAL;
                P_ISS:             part_o = (nxt.tag[4:0] == TAG_SEQ_NUM) ? PART_ISSUER
                                                                          : PART_NONE;
                P_ISSBODY:         part_o = PART_ISSUER;
                default:           part_o = PART_NONE;
            endcase
        end

        // Verdict on the final byte, then start over
        if (last_i) begin
            lt_outer = outer_done ? (nxt.len_acc != 32'd0)
                                  : ({1'b0, nxt.seen} < st_i.outer_end);
            if (nxt.phase == P_OUTER) begin
                status_o = (nxt.hstep == HS_EXT) ? ST_BADLEN : ST_TRUNC;
            end else if (lt_outer) begin
                status_o = ST_OVER;
            end else if (nxt.err != ST_BUSY) begin
                status_o = nxt.err;
            end else if (nxt.phase == P_ISSBODY || nxt.phase == P_TAIL) begin
                status_o = ST_OK;
            end else begin
                status_o = ST_TRUNC;
            end
            nxt = STATE_RESET;
        end
    end

    assign st_o = nxt;

endmodule

FILE: design/der_cert_serial_issuer_extractor.sv
// Top level: stream wrapper around the DER certificate serial and issuer parser.
//
// Takes a DER certificate one byte per transaction (tlast on the final byte) and returns
// one transaction per byte: the byte, a mark for serial-number or issuer TLV bytes, and on
// the final byte the verdict (1 ok, 2..8 error codes; 0 on all other bytes). One byte is
// taken every cycle when the output side is ready; each byte is held in the input register,
// then passes through the parse stage into the output register once the output side can take it.
// The rate is set by the per-byte state update, which is combinational. The state
// returns to reset after the final byte.
`include "der_cert_serial_issuer_extractor_defines.svh"

module der_cert_serial_issuer_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [11:8] status, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] part
);
    import der_csi_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] out_part_reg;
    logic [3:0] out_status_reg;
    logic [1:0] part_next;
    logic [3:0] status_next;
    logic       adv;
    logic       s_accept;

    // Handshake
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse step
    der_csi_step u_step (
        .st_i     (state_reg),
        .byte_i   (in_data_reg),
        .last_i   (in_last_reg),
        .st_o     (state_next),
        .part_o   (part_next),
        .status_o (status_next)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_byte_reg   <= in_data_reg;
            out_part_reg   <= part_next;
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_status_reg, out_byte_reg};
    assign m_tuser  = out_part_reg;

    // Checks
    `DCSI_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(state_reg.phase), "phase not one-hot")
    `DCSI_ASSERT_NOW(a_err_in_tail, state_reg.err != ST_BUSY, state_reg.phase == P_TAIL,
        "error set outside tail phase")
    `DCSI_ASSERT_NEXT(a_frame_reset, adv && in_last_reg,
        state_reg.phase == P_OUTER && state_reg.err == ST_BUSY && state_reg.seen == 33'd0,
        "state not cleared after final byte")

endmodule
